FILE: rtl/etrm_pkg.sv
`default_nettype none
package etrm_pkg;

  localparam int AngleBits = 16;
  localparam int FracBits  = 14;
  localparam int WorkFrac  = 30;
  localparam int OutBits   = 16;
  localparam int NumSteps  = 5;

  localparam logic [31:0] HalfPiQ30 = 32'd1686629713;
  localparam logic [31:0] WorkOne   = 32'h4000_0000;
  localparam logic [61:0] WorkHalf  = 62'h2000_0000;

  typedef struct packed {
    logic [15:0] pitch_angle;
    logic [15:0] yaw_angle;
    logic [15:0] roll_angle;
  } etrm_in_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } etrm_out_t;

  // Q30 magnitude product, rounded half up
  function automatic logic [31:0] umul_q30(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b) + 64'(WorkHalf);
    return p[61:30];
  endfunction

  // signed Q30 product: magnitudes, round, then sign
  function automatic logic signed [32:0] smul_q30(input logic signed [32:0] a,
                                                  input logic signed [32:0] b);
    logic [32:0] ma;
    logic [32:0] mb;
    logic [31:0] m;
    ma = a[32] ? 33'(-a) : 33'(a);
    mb = b[32] ? 33'(-b) : 33'(b);
    m  = umul_q30(ma[31:0], mb[31:0]);
    return (a[32] ^ b[32]) ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  function automatic logic [15:0] to_field(input logic signed [33:0] v);
    logic [33:0] m;
    logic [33:0] r;
    m = v[33] ? 34'(-v) : 34'(v);
    r = (m + 34'(1 << (WorkFrac - FracBits - 1))) >> (WorkFrac - FracBits);
    if (r > 34'(1 << FracBits)) begin
      r = 34'(1 << FracBits);
    end
    r = v[33] ? 34'(-r) : r;
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/euler_to_rotation_matrix.sv
`default_nettype none
// Euler angles to 3x3 rotation matrix. One transaction per clock: busy_o is
// always low, so every start_i cycle is taken. The result strobes on done_o
// after 13 trig stages, 2 product stages and 1 output register, and must be
// taken that cycle, since the receiver cannot stall.
module euler_to_rotation_matrix import etrm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  output logic          busy_o,
  input  wire etrm_in_t in_i,
  output logic          done_o,
  output etrm_out_t     out_o
);

  localparam int Lat = 16;

  assign busy_o = 1'b0;

  logic [Lat-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start_i};
    end
  end

  logic signed [32:0] sp, cp, sy, cy, sr, cr;
  etrm_trig u_pitch (.clk_i, .angle_i(in_i.pitch_angle), .sin_o(sp), .cos_o(cp));
  etrm_trig u_yaw   (.clk_i, .angle_i(in_i.yaw_angle),   .sin_o(sy), .cos_o(cy));
  etrm_trig u_roll  (.clk_i, .angle_i(in_i.roll_angle),  .sin_o(sr), .cos_o(cr));

  // product stage A
  logic signed [32:0] spsy_q, cpsy_q, cycr_q, cysr_q, cpcr_q, spsr_q, spcr_q;
  logic signed [32:0] spcy_q, cpcy_q, cpsr_q, sy_a_q, sr_a_q, cr_a_q;
  always_ff @(posedge clk_i) begin
    spsy_q <= smul_q30(sp, sy);
    cpsy_q <= smul_q30(cp, sy);
    cycr_q <= smul_q30(cy, cr);
    cysr_q <= smul_q30(cy, sr);
    cpcr_q <= smul_q30(cp, cr);
    spsr_q <= smul_q30(sp, sr);
    spcr_q <= smul_q30(sp, cr);
    spcy_q <= smul_q30(sp, cy);
    cpcy_q <= smul_q30(cp, cy);
    cpsr_q <= smul_q30(cp, sr);
    sy_a_q <= sy;
    sr_a_q <= sr;
    cr_a_q <= cr;
  end

  // product stage B
  logic signed [32:0] t01_q, t02_q, t11_q, t12_q;
  logic signed [32:0] b_cycr_q, b_cysr_q, b_cpcr_q, b_spsr_q, b_spcr_q;
  logic signed [32:0] b_spcy_q, b_cpcy_q, b_cpsr_q, b_sy_q;
  always_ff @(posedge clk_i) begin
    t01_q    <= smul_q30(spsy_q, cr_a_q);
    t02_q    <= smul_q30(cpsy_q, cr_a_q);
    t11_q    <= smul_q30(spsy_q, sr_a_q);
    t12_q    <= smul_q30(cpsy_q, sr_a_q);
    b_cycr_q <= cycr_q;
    b_cysr_q <= cysr_q;
    b_cpcr_q <= cpcr_q;
    b_spsr_q <= spsr_q;
    b_spcr_q <= spcr_q;
    b_spcy_q <= spcy_q;
    b_cpcy_q <= cpcy_q;
    b_cpsr_q <= cpsr_q;
    b_sy_q   <= sy_a_q;
  end

  // sums and output conversion
  etrm_out_t res_q;
  always_ff @(posedge clk_i) begin
    res_q.m00 <= to_field(34'(b_cycr_q));
    res_q.m01 <= to_field(34'(t01_q) - 34'(b_cpsr_q));
    res_q.m02 <= to_field(34'(b_spsr_q) + 34'(t02_q));
    res_q.m10 <= to_field(34'(b_cysr_q));
    res_q.m11 <= to_field(34'(b_cpcr_q) + 34'(t11_q));
    res_q.m12 <= to_field(34'(t12_q) - 34'(b_spcr_q));
    res_q.m20 <= to_field(-34'(b_sy_q));
    res_q.m21 <= to_field(34'(b_spcy_q));
    res_q.m22 <= to_field(34'(b_cpcy_q));
  end

  assign out_o  = res_q;
  assign done_o = vld_q[Lat-1];

endmodule
`default_nettype wire

FILE: rtl/etrm_trig.sv
`default_nettype none
module etrm_trig import etrm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic [15:0]        angle_i,
  output logic signed [32:0]      sin_o,
  output logic signed [32:0]      cos_o
);

  // stage 0: reduce, radians
  logic [31:0] u;
  logic [29:0] t;
  logic [30:0] tr;
  logic [63:0] xp;
  assign u  = {angle_i[AngleBits-1:0], {(32-AngleBits){1'b0}}};
  assign t  = u[29:0];
  assign tr = t[29] ? 31'(31'h4000_0000 - 31'(t)) : 31'(t);
  assign xp = 64'(tr) * 64'(HalfPiQ30) + 64'(WorkHalf);

  logic [31:0] x_q0;
  logic [1:0]  q_q0;
  logic        r_q0;
  always_ff @(posedge clk_i) begin
    x_q0 <= xp[61:30];
    q_q0 <= u[31:30];
    r_q0 <= t[29];
  end

  // stage 1: x squared
  logic [63:0] x2p;
  assign x2p = 64'(x_q0) * 64'(x_q0) + 64'(WorkHalf);

  // five Horner steps, sine and cosine lanes in parallel; each step is a
  // product stage followed by a divide-by-constant stage
  localparam logic [6:0] KS [NumSteps] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [6:0] KC [NumSteps] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
  localparam int ShS [NumSteps] = '{37, 37, 36, 35, 33};
  localparam int ShC [NumSteps] = '{37, 36, 35, 34, 31};
  logic [31:0] ps_q [NumSteps+1];
  logic [31:0] pc_q [NumSteps+1];
  logic [31:0] xs_q [NumSteps+1];
  logic [31:0] x2s_q [NumSteps];
  logic [1:0]  qs_q [NumSteps+1];
  logic        rs_q [NumSteps+1];
  logic [29:0] fs_q [NumSteps];
  logic [29:0] fc_q [NumSteps];
  logic [31:0] xm_q [NumSteps];
  logic [31:0] x2m_q [NumSteps-1];
  logic [1:0]  qm_q [NumSteps];
  logic        rm_q [NumSteps];
  always_ff @(posedge clk_i) begin
    ps_q[0]  <= WorkOne;
    pc_q[0]  <= WorkOne;
    xs_q[0]  <= x_q0;
    x2s_q[0] <= x2p[61:30];
    qs_q[0]  <= q_q0;
    rs_q[0]  <= r_q0;
  end
  for (genvar i = 0; i < NumSteps; i++) begin : g_step
    localparam logic [31:0] MulS =
      32'(((64'd1 << ShS[i]) + 64'(KS[i]) - 64'd1) / 64'(KS[i]));
    localparam logic [31:0] MulC =
      32'(((64'd1 << ShC[i]) + 64'(KC[i]) - 64'd1) / 64'(KC[i]));
    logic [63:0] prs, prc, dvs, dvc;
    assign prs = 64'(x2s_q[i]) * 64'(ps_q[i]);
    assign prc = 64'(x2s_q[i]) * 64'(pc_q[i]);
    always_ff @(posedge clk_i) begin
      fs_q[i] <= prs[59:30];
      fc_q[i] <= prc[59:30];
      xm_q[i] <= xs_q[i];
      qm_q[i] <= qs_q[i];
      rm_q[i] <= rs_q[i];
    end
    // floor(f/k) as f * ceil(2^s/k) >> s, exact for f below 2^30
    assign dvs = 64'(fs_q[i]) * 64'(MulS);
    assign dvc = 64'(fc_q[i]) * 64'(MulC);
    always_ff @(posedge clk_i) begin
      ps_q[i+1] <= WorkOne - 32'(dvs >> ShS[i]);
      pc_q[i+1] <= WorkOne - 32'(dvc >> ShC[i]);
      xs_q[i+1] <= xm_q[i];
      qs_q[i+1] <= qm_q[i];
      rs_q[i+1] <= rm_q[i];
    end
    if (i < NumSteps - 1) begin : g_x2
      always_ff @(posedge clk_i) begin
        x2m_q[i]   <= x2s_q[i];
        x2s_q[i+1] <= x2m_q[i];
      end
    end
  end

  // final: sine scale, reflect, quadrant
  logic [31:0] s;
  logic signed [32:0] sv, cv;
  assign s  = umul_q30(xs_q[NumSteps], ps_q[NumSteps]);
  assign sv = rs_q[NumSteps] ? $signed({1'b0, pc_q[NumSteps]}) : $signed({1'b0, s});
  assign cv = rs_q[NumSteps] ? $signed({1'b0, s}) : $signed({1'b0, pc_q[NumSteps]});
  always_ff @(posedge clk_i) begin
    case (qs_q[NumSteps])
      2'd0: begin sin_o <= sv;  cos_o <= cv;  end
      2'd1: begin sin_o <= cv;  cos_o <= -sv; end
      2'd2: begin sin_o <= -sv; cos_o <= -cv; end
      default: begin sin_o <= -cv; cos_o <= sv; end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/etrm_checker.sv
`default_nettype none
module etrm_checker import etrm_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      start_i,
  input wire logic      busy_o,
  input wire logic      done_o,
  input wire etrm_out_t out_o
);

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##16 done_o) else $error("result missing");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 16)) else $error("spurious result");

  a_m20_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($signed(out_o.m20) <= 16384 && $signed(out_o.m20) >= -16384))
    else $error("entry out of range");

endmodule

bind euler_to_rotation_matrix etrm_checker u_etrm_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .out_o
);
`default_nettype wire

FILE: dv/etrm_checker.sv
module etrm_tb_checker import etrm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      busy_i,
  input  etrm_in_t  in_i,
  input  logic      done_i,
  input  etrm_out_t out_i,
  output int        fail_cnt_o,
  output int        pending_o,
  output int        matrix_cnt_o
);

  typedef struct {
    longint sn;
    longint cs;
  } sincos_t;

  etrm_out_t matrix_q[$];

  function automatic longint horner(longint x2, longint p, longint k);
    return 64'h4000_0000 - ((x2 * p) >>> 30) / k;
  endfunction

  function automatic sincos_t angle_sincos(logic [15:0] ang);
    logic [31:0] u;
    logic [1:0]  quad;
    longint      t, x, x2, p, s, c, sv, cv;
    sincos_t     r;
    u    = {ang, 16'h0};
    quad = u[31:30];
    t    = longint'(u[29:0]);
    if (u[29]) t = 64'h4000_0000 - t;
    x  = (t * 1686629713 + 64'h2000_0000) >>> 30;
    x2 = (x * x + 64'h2000_0000) >>> 30;
    p = 64'h4000_0000;
    p = horner(x2, p, 110);
    p = horner(x2, p, 72);
    p = horner(x2, p, 42);
    p = horner(x2, p, 20);
    p = horner(x2, p, 6);
    s = (x * p + 64'h2000_0000) >>> 30;
    p = 64'h4000_0000;
    p = horner(x2, p, 90);
    p = horner(x2, p, 56);
    p = horner(x2, p, 30);
    p = horner(x2, p, 12);
    p = horner(x2, p, 2);
    c = p;
    if (u[29]) begin
      sv = c;
      cv = s;
    end else begin
      sv = s;
      cv = c;
    end
    case (quad)
      2'd0: begin r.sn = sv;  r.cs = cv;  end
      2'd1: begin r.sn = cv;  r.cs = -sv; end
      2'd2: begin r.sn = -sv; r.cs = -cv; end
      default: begin r.sn = -cv; r.cs = sv; end
    endcase
    return r;
  endfunction

  function automatic longint qprod(longint a, longint b);
    longint ma, mb, m;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    m  = (ma * mb + 64'h2000_0000) >>> 30;
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  function automatic logic [15:0] q14(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'd1 << 15)) >>> 16;
    if (m > 16384) m = 16384;
    if (v < 0) m = -m;
    return m[15:0];
  endfunction

  function automatic etrm_out_t rotation(etrm_in_t a);
    sincos_t   pt, yw, rl;
    etrm_out_t o;
    pt = angle_sincos(a.pitch_angle);
    yw = angle_sincos(a.yaw_angle);
    rl = angle_sincos(a.roll_angle);
    o.m00 = q14(qprod(yw.cs, rl.cs));
    o.m01 = q14(qprod(qprod(pt.sn, yw.sn), rl.cs) - qprod(pt.cs, rl.sn));
    o.m02 = q14(qprod(pt.sn, rl.sn) + qprod(qprod(pt.cs, yw.sn), rl.cs));
    o.m10 = q14(qprod(yw.cs, rl.sn));
    o.m11 = q14(qprod(pt.cs, rl.cs) + qprod(qprod(pt.sn, yw.sn), rl.sn));
    o.m12 = q14(qprod(qprod(pt.cs, yw.sn), rl.sn) - qprod(pt.sn, rl.cs));
    o.m20 = q14(-yw.sn);
    o.m21 = q14(qprod(pt.sn, yw.cs));
    o.m22 = q14(qprod(pt.cs, yw.cs));
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d want %0d (matrix %0d)", what, $signed(got),
             $signed(want), matrix_cnt_o);
    fail_cnt_o++;
  endtask

  initial begin
    fail_cnt_o   = 0;
    matrix_cnt_o = 0;
  end

  assign pending_o = matrix_q.size();

  always @(posedge clk_i) begin
    etrm_out_t w;
    if (rst_ni) begin
      if (done_i) begin
        if (matrix_q.size() == 0) begin
          report_mismatch("unexpected transaction", out_i.m00, 16'h0);
        end else begin
          w = matrix_q.pop_front();
          if (out_i.m00 !== w.m00) report_mismatch("m00", out_i.m00, w.m00);
          if (out_i.m01 !== w.m01) report_mismatch("m01", out_i.m01, w.m01);
          if (out_i.m02 !== w.m02) report_mismatch("m02", out_i.m02, w.m02);
          if (out_i.m10 !== w.m10) report_mismatch("m10", out_i.m10, w.m10);
          if (out_i.m11 !== w.m11) report_mismatch("m11", out_i.m11, w.m11);
          if (out_i.m12 !== w.m12) report_mismatch("m12", out_i.m12, w.m12);
          if (out_i.m20 !== w.m20) report_mismatch("m20", out_i.m20, w.m20);
          if (out_i.m21 !== w.m21) report_mismatch("m21", out_i.m21, w.m21);
          if (out_i.m22 !== w.m22) report_mismatch("m22", out_i.m22, w.m22);
        end
        matrix_cnt_o++;
      end
      if (start_i && !busy_i) matrix_q.push_back(rotation(in_i));
    end
  end

endmodule

FILE: dv/tb_euler_to_rotation_matrix.sv
module tb_euler_to_rotation_matrix;
  import etrm_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  logic      busy_o;
  etrm_in_t  in_i;
  logic      done_o;
  etrm_out_t out_o;
  int        fail_cnt;
  int        pending;
  int        matrix_cnt;
  int        cycle_cnt;
  int        sent_cnt;

  euler_to_rotation_matrix i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .in_i, .done_o, .out_o
  );

  etrm_tb_checker i_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .in_i, .done_i(done_o), .out_i(out_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending), .matrix_cnt_o(matrix_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > 200000) begin
        $display("timeout after %0d cycles", cycle_cnt);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 16'({$urandom_range(0, 7), 13'h0});
      1: return 16'({$urandom_range(0, 7), 13'h0} + $urandom_range(0, 4) - 2);
      default: return 16'($urandom);
    endcase
  endfunction

  // one transaction; sender idles with the given percentage
  task automatic send(etrm_in_t a, int idle_pct);
    while ($urandom_range(1, 100) <= idle_pct) begin
      start_i <= 1'b0;
      in_i    <= etrm_in_t'($urandom);
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= a;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  initial begin
    logic [15:0] edge_ang [10];
    etrm_in_t a;
    int idle_pct;
    edge_ang = '{16'h0000, 16'hFFFF, 16'h2000, 16'h4000, 16'h6000, 16'h8000,
                 16'hC000, 16'h1FFF, 16'h2001, 16'h5555};
    sent_cnt = 0;
    rst_ni   = 1'b0;
    start_i  = 1'b0;
    in_i     = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < 10; i++) begin
      send('{edge_ang[i], edge_ang[(i + 3) % 10], edge_ang[(i + 7) % 10]}, 0);
    end
    for (int i = 0; i < 10; i++) begin
      send('{16'hFFFF ^ edge_ang[i], edge_ang[i], 16'h0000}, 0);
    end
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 55;
        2: idle_pct = 0;
        default: idle_pct = 25;
      endcase
      for (int i = 0; i < 128; i++) begin
        a.pitch_angle = pick_angle();
        a.yaw_angle   = pick_angle();
        a.roll_angle  = pick_angle();
        send(a, idle_pct);
      end
    end
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("sent %0d angle triples, checked %0d matrices", sent_cnt, matrix_cnt);
    $display("covered octant edges, wraparound and random angles under idle mixes");
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
